/* sv/usd_pkg.sv */
package usd_pkg;

  localparam int unsigned CpWidth      = 21;
  localparam int unsigned DefQueueDepth = 4;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam logic [2:0] SeqIdle = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // One request's worth of results: n_flush invalid bytes, then an optional tail.
  typedef struct packed {
    logic [1:0]         n_flush;
    logic               has_tail;
    logic               tail_valid;
    logic [CpWidth-1:0] tail_cp;
    logic [2:0]         tail_cnt;
  } job_t;

endpackage

/* sv/usd_front.sv */
module usd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  input  logic          full,
  input  logic [7:0]    in_byte_i,
  output logic          job_push_o,
  output usd_pkg::job_t job_o
);
  import usd_pkg::*;

  logic [2:0]         seq_len_q, seq_len_d;
  logic [1:0]         cont_q, cont_d;
  logic [CpWidth-1:0] acc_q, acc_d;
  logic               pending;
  logic               is_cont;
  logic [1:0]         cont_inc;
  logic [CpWidth-1:0] acc_shift;

  assign pending   = (seq_len_q != SeqIdle);
  assign is_cont   = ((in_byte_i & ContMask) == ContCode);
  assign cont_inc  = cont_q + 2'd1;
  assign acc_shift = {acc_q[CpWidth-7:0], in_byte_i[5:0]};

  always_comb begin
    seq_len_d  = seq_len_q;
    cont_d     = cont_q;
    acc_d      = acc_q;
    job_o      = '0;
    if (push && !full) begin
      if (pending && is_cont) begin
        acc_d  = acc_shift;
        cont_d = cont_inc;
        if (({1'b0, cont_inc} + 3'd1) >= seq_len_q) begin
          job_o.has_tail   = 1'b1;
          job_o.tail_valid = 1'b1;
          job_o.tail_cp    = acc_shift;
          job_o.tail_cnt   = seq_len_q;
          seq_len_d        = SeqIdle;
          cont_d           = 2'd0;
          acc_d            = '0;
        end
      end else begin
        seq_len_d     = SeqIdle;
        cont_d        = 2'd0;
        acc_d         = '0;
        job_o.n_flush = pending ? cont_inc : 2'd0;
        if (in_byte_i == 8'h00) begin
          // end of string
        end else if (!in_byte_i[7]) begin
          job_o.has_tail   = 1'b1;
          job_o.tail_valid = 1'b1;
          job_o.tail_cp    = {{(CpWidth-8){1'b0}}, in_byte_i};
          job_o.tail_cnt   = 3'd1;
        end else if ((in_byte_i & Lead2Mask) == Lead2Code) begin
          seq_len_d = SeqLen2;
          acc_d     = {{(CpWidth-5){1'b0}}, in_byte_i[4:0]};
        end else if ((in_byte_i & Lead3Mask) == Lead3Code) begin
          seq_len_d = SeqLen3;
          acc_d     = {{(CpWidth-4){1'b0}}, in_byte_i[3:0]};
        end else if ((in_byte_i & Lead4Mask) == Lead4Code) begin
          seq_len_d = SeqLen4;
          acc_d     = {{(CpWidth-3){1'b0}}, in_byte_i[2:0]};
        end else begin
          job_o.has_tail = 1'b1;
          job_o.tail_cnt = 3'd1;
        end
      end
    end
  end

  assign job_push_o = job_o.has_tail || (job_o.n_flush != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SeqIdle;
      cont_q    <= 2'd0;
      acc_q     <= '0;
    end else begin
      seq_len_q <= seq_len_d;
      cont_q    <= cont_d;
      acc_q     <= acc_d;
    end
  end

`ifndef SYNTHESIS
  a_seq_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_len_q == SeqIdle || seq_len_q == SeqLen2 || seq_len_q == SeqLen3 ||
    seq_len_q == SeqLen4)
    else $error("illegal pending sequence length");
  a_cont_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending |-> ({1'b0, cont_q} + 3'd1 < seq_len_q))
    else $error("continuation count reached sequence length while pending");
`endif

endmodule

/* sv/usd_fifo.sv */
module usd_fifo #(
  parameter int unsigned Depth = usd_pkg::DefQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  usd_pkg::job_t wdata_i,
  input  logic          rd_i,
  output usd_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import usd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i)
    else $error("job queue write while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !rd_i)
    else $error("job queue read while empty");
`endif

endmodule

/* sv/usd_back.sv */
module usd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  usd_pkg::job_t               job_i,
  input  logic                        job_empty_i,
  output logic                        job_rd_o,
  input  logic                        pop,
  output logic                        empty,
  output logic [usd_pkg::CpWidth-1:0] codepoint_o,
  output logic                        is_valid_o,
  output logic [2:0]                  byte_count_o,
  output logic                        last_of_run_o
);
  import usd_pkg::*;

  logic               out_vld_q;
  logic [1:0]         idx_q;
  logic [2:0]         total;
  logic               is_flush;
  logic               is_last;
  logic               load;
  logic [CpWidth-1:0] cp_q;
  logic               vld_q;
  logic [2:0]         cnt_q;
  logic               last_q;

  assign total    = {1'b0, job_i.n_flush} + {2'b00, job_i.has_tail};
  assign is_flush = (idx_q < job_i.n_flush);
  assign is_last  = (({1'b0, idx_q} + 3'd1) == total);
  assign load     = !job_empty_i && (!out_vld_q || pop);
  assign job_rd_o = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= is_flush ? '0 : job_i.tail_cp;
      vld_q  <= is_flush ? 1'b0 : job_i.tail_valid;
      cnt_q  <= is_flush ? 3'd1 : job_i.tail_cnt;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty         = !out_vld_q;
  assign codepoint_o   = cp_q;
  assign is_valid_o    = vld_q;
  assign byte_count_o  = cnt_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> ({1'b0, idx_q} < total))
    else $error("result index past end of job");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !vld_q) |-> (cp_q == '0 && cnt_q == 3'd1))
    else $error("invalid result with nonzero payload");
`endif

endmodule

/* sv/utf8_stream_decoder.sv */
// UTF-8 stream decoder: one raw byte is taken per cycle while full is low, and
// each byte yields zero to four results (code point, valid flag, byte count,
// last-of-run marker). A front stage tracks the pending multi-byte sequence and
// turns each byte with results into a job; a job queue of QueueDepth entries
// feeds a back stage that puts the results out one per cycle while its output
// register is empty or popped. Plain text sustains one byte per cycle while
// results are popped; a byte that cuts off a pending sequence gives up to four
// results, so the result port sets the rate during error bursts. A zero byte
// ends the string and gives results only for a sequence it cuts off.
module utf8_stream_decoder #(
  parameter int unsigned QueueDepth = usd_pkg::DefQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [usd_pkg::CpWidth-1:0] codepoint_o,
  output logic                        is_valid_o,
  output logic [2:0]                  byte_count_o,
  output logic                        last_of_run_o
);
  import usd_pkg::*;

  job_t job_in, job_out;
  logic job_push, job_rd, job_empty;

  usd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  usd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (job_in),
    .rd_i    (job_rd),
    .rdata_o (job_out),
    .full_o  (full),
    .empty_o (job_empty)
  );

  usd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_empty_i   (job_empty),
    .job_rd_o      (job_rd),
    .pop           (pop),
    .empty         (empty),
    .codepoint_o   (codepoint_o),
    .is_valid_o    (is_valid_o),
    .byte_count_o  (byte_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import usd_pkg::*;

  typedef struct packed {
    logic [CpWidth-1:0] codepoint;
    logic               is_valid;
    logic [2:0]         byte_count;
    logic               last_of_run;
  } cp_result_t;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 96;
  localparam int unsigned RandomBytes = 76;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               push      = 1'b0;
  logic               pop       = 1'b0;
  logic [7:0]         in_byte_i = 8'h00;
  logic               full;
  logic               empty;
  logic [CpWidth-1:0] codepoint_o;
  logic               is_valid_o;
  logic [2:0]         byte_count_o;
  logic               last_of_run_o;

  logic [7:0]         text_bytes[$];
  cp_result_t         expected_cps[$];

  // decoder state as predicted
  logic [2:0]         seq_len    = SeqIdle;
  logic [1:0]         conts_seen = 2'd0;
  logic [CpWidth-1:0] cp_acc     = '0;

  int unsigned bytes_sent  = 0;
  int unsigned bytes_taken = 0;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_gap      = 0;
  int unsigned rx_stall    = 0;
  logic        tx_steady   = 1'b0;
  logic        rx_steady   = 1'b0;

  utf8_stream_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .empty        (empty),
    .pop          (pop),
    .codepoint_o  (codepoint_o),
    .is_valid_o   (is_valid_o),
    .byte_count_o (byte_count_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cp_result_t make_result(input logic [CpWidth-1:0] cp, input logic ok,
                                             input logic [2:0] cnt);
    cp_result_t r;
    r.codepoint   = cp;
    r.is_valid    = ok;
    r.byte_count  = cnt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    cp_result_t res[$];
    if (seq_len != SeqIdle && (b & ContMask) == ContCode) begin
      cp_acc     = {cp_acc[CpWidth-7:0], b[5:0]};
      conts_seen = conts_seen + 2'd1;
      if (int'(conts_seen) + 1 >= int'(seq_len)) begin
        res.push_back(make_result(cp_acc, 1'b1, seq_len));
        seq_len    = SeqIdle;
        conts_seen = 2'd0;
        cp_acc     = '0;
      end
    end else begin
      // a cut-off sequence: lead plus each continuation taken go out as invalid
      if (seq_len != SeqIdle) begin
        res.push_back(make_result('0, 1'b0, 3'd1));
        repeat (conts_seen) res.push_back(make_result('0, 1'b0, 3'd1));
      end
      seq_len    = SeqIdle;
      conts_seen = 2'd0;
      cp_acc     = '0;
      if (b == 8'h00) begin
      end else if (!b[7]) begin
        res.push_back(make_result(CpWidth'(b), 1'b1, 3'd1));
      end else if ((b & Lead2Mask) == Lead2Code) begin
        seq_len = SeqLen2;
        cp_acc  = CpWidth'(b[4:0]);
      end else if ((b & Lead3Mask) == Lead3Code) begin
        seq_len = SeqLen3;
        cp_acc  = CpWidth'(b[3:0]);
      end else if ((b & Lead4Mask) == Lead4Code) begin
        seq_len = SeqLen4;
        cp_acc  = CpWidth'(b[2:0]);
      end else begin
        res.push_back(make_result('0, 1'b0, 3'd1));
      end
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) expected_cps.push_back(res[i]);
  endtask

  // queue the first 'keep' bytes of a random nbytes-long character
  task automatic queue_char(input int unsigned nbytes, input int unsigned keep);
    logic [7:0] seq[4];
    case (nbytes)
      1: seq[0] = 8'($urandom_range(8'h01, 8'h7F));
      2: seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
      3: seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
      default: seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
    endcase
    for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'h80, 8'hBF));
    for (int i = 0; i < int'(keep); i++) text_bytes.push_back(seq[i]);
  endtask

  always @(negedge clk_i) begin
    logic next_push;
    if (rst_ni) begin
      next_push = push;
      if (push && bytes_taken == bytes_sent) next_push = 1'b0;
      if (!next_push) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (text_bytes.size() > 0) begin
          in_byte_i <= text_bytes.pop_front();
          next_push = 1'b1;
          bytes_sent++;
          tx_gap = tx_steady ? 0 : gap_len();
          if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
        end
      end
      push <= next_push;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        rx_stall = rx_steady ? 0 : gap_len();
        if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      end
    end
  end

  always @(posedge clk_i) begin
    cp_result_t want;
    logic       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (push && !full) begin
        decode_byte(in_byte_i);
        bytes_taken++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_cps.size() == 0) begin
          $error("unexpected result: codepoint %0h valid %0b", codepoint_o, is_valid_o);
          fail_count++;
        end else begin
          want = expected_cps.pop_front();
          if (codepoint_o !== want.codepoint) begin
            $error("codepoint: expected %0h, got %0h", want.codepoint, codepoint_o);
            fail_count++;
          end
          if (is_valid_o !== want.is_valid) begin
            $error("is_valid: expected %0b, got %0b", want.is_valid, is_valid_o);
            fail_count++;
          end
          if (byte_count_o !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, byte_count_o);
            fail_count++;
          end
          if (last_of_run_o !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, last_of_run_o);
            fail_count++;
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned queued;
    int unsigned r;
    // ends of the byte range, stray continuations, F8..FF, string end
    text_bytes = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF};
    // 2-, 3- and 4-byte characters, the highest 4-byte form
    text_bytes.push_back(8'hC2); text_bytes.push_back(8'hA9);
    text_bytes.push_back(8'hE2); text_bytes.push_back(8'h82); text_bytes.push_back(8'hAC);
    text_bytes.push_back(8'hF7); text_bytes.push_back(8'hBF);
    text_bytes.push_back(8'hBF); text_bytes.push_back(8'hBF);
    // cut off after three bytes by a bad byte: four invalid results from one byte
    text_bytes.push_back(8'hF0); text_bytes.push_back(8'h9F);
    text_bytes.push_back(8'h98); text_bytes.push_back(8'hFF);
    // pending sequence flushed by string end, and by plain ASCII
    text_bytes.push_back(8'hC3); text_bytes.push_back(8'h00);
    text_bytes.push_back(8'hE1); text_bytes.push_back(8'h41);

    queued = 0;
    while (queued < RandomBytes) begin
      r = $urandom_range(0, 99);
      queued -= text_bytes.size();
      if (r < 20) queue_char(1, 1);
      else if (r < 38) queue_char(2, 2);
      else if (r < 54) queue_char(3, 3);
      else if (r < 68) queue_char(4, 4);
      else if (r < 80) begin
        r = $urandom_range(2, 4);
        queue_char(r, $urandom_range(1, r - 1));
      end else if (r < 85) text_bytes.push_back(8'h00);
      else if (r < 91) text_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      else if (r < 95) text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
      else text_bytes.push_back(8'($urandom_range(0, 255)));
      queued += text_bytes.size();
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_bytes.size() > 0 || push) @(posedge clk_i);
    while (expected_cps.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* utf8_stream_decoder.f */
sv/usd_pkg.sv
sv/usd_front.sv
sv/usd_fifo.sv
sv/usd_back.sv
sv/utf8_stream_decoder.sv
tb/tb.sv
